// File: sv/apc_pkg.sv
// Package for the pileup counter: request codes, base letters, counter slots,
// queue command and response types, back-end states.
// No dependencies; every other file but apc_if imports it.
package apc_pkg;

    localparam int NUM_CNT   = 8;
    localparam int CNT_OUT_W = 16;
    localparam int Q_DEPTH   = 4;

    localparam logic [2:0] REQ_START  = 3'd0;
    localparam logic [2:0] REQ_MATCH  = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [2:0] {
        SLOT_A = 3'd0,
        SLOT_C = 3'd1,
        SLOT_G = 3'd2,
        SLOT_T = 3'd3,
        SLOT_N = 3'd4,
        SLOT_M = 3'd5,
        SLOT_I = 3'd6,
        SLOT_D = 3'd7
    } t_slot;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MATCH,
        OP_DELETE,
        OP_INSERT,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op   op;
        t_slot slot;
        logic  has_letter;
        logic  oor;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                          status;
        logic [NUM_CNT-1:0][CNT_OUT_W-1:0]  count;
    } t_rsp;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DATA
    } t_bk_state;

endpackage

// File: sv/apc_if.sv
// Request and response channel interfaces of the pileup counter.
// No dependencies.
interface apc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] position;
    logic [7:0]  base;

    modport source (output valid, output req_type, output position, output base,
                    input ready);
    modport sink (input valid, input req_type, input position, input base,
                  output ready);
endinterface

interface apc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] count_a;
    logic [15:0] count_c;
    logic [15:0] count_g;
    logic [15:0] count_t;
    logic [15:0] count_n;
    logic [15:0] count_match;
    logic [15:0] count_insert;
    logic [15:0] count_delete;

    modport source (output valid, output status, output count_a, output count_c,
                    output count_g, output count_t, output count_n, output count_match,
                    output count_insert, output count_delete, input ready);
    modport sink (input valid, input status, input count_a, input count_c,
                  input count_g, input count_t, input count_n, input count_match,
                  input count_insert, input count_delete, output ready);
endinterface

// File: sv/alignment_pileup_counter.sv
// Top level of the pileup counter: front end, command queue and table back end.
// Depends on apc_pkg, apc_if, apc_front, apc_queue and apc_back.
//
//   Channel   Dir   Modport        Payload
//   i_req     in    apc_req_if     req_type, position, base
//   o_rsp     out   apc_rsp_if     status, count_a .. count_delete
//
// Each request takes a registered table read, then the counter update, write back
// and response load; the back end starts the next one only after that load and
// while the output register is empty or being taken. The front end takes requests
// into a four-entry queue, so it keeps accepting, until the queue fills, while a
// response waits in the output register. After reset a clearing pass writes
// TABLE_DEPTH entries, one per cycle, and no request is accepted until it ends.
module alignment_pileup_counter #(
    parameter int TABLE_DEPTH = 65536,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apc_req_if.sink    i_req,
    apc_rsp_if.source  o_rsp
);
    import apc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic              push;
    t_cmd              f_cmd;
    logic [ADDR_W-1:0] f_addr;
    logic              q_full;
    logic              q_valid;
    t_cmd              q_cmd;
    logic [ADDR_W-1:0] q_addr;
    logic              pop;
    logic              clear_busy;

    apc_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_clear_busy (clear_busy),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_addr       (f_addr)
    );

    apc_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr),
        .i_pop   (pop)
    );

    apc_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .i_q_addr     (q_addr),
        .o_pop        (pop),
        .o_clear_busy (clear_busy),
        .o_rsp        (o_rsp)
    );

endmodule

// File: sv/apc_front.sv
// Front end: accepts requests, keeps the walk pointer, classifies each request
// into a table command and address. Depends on apc_pkg and apc_if.
module apc_front #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    apc_req_if.sink          i_req,
    input  logic             i_clear_busy,
    input  logic             i_q_full,
    output logic             o_push,
    output apc_pkg::t_cmd    o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_addr
);
    import apc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PTR_W  = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(TABLE_DEPTH);

    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;
    logic [PTR_W-1:0] pos_ext;
    logic [PTR_W-1:0] ptr_m1;
    logic             ptr_ok;

    assign i_req.ready = !i_clear_busy && !i_q_full;
    assign o_push      = i_req.valid && i_req.ready;

    assign pos_ext = PTR_W'(i_req.position);
    assign ptr_m1  = r_ptr - PTR_W'(1);
    assign ptr_ok  = r_ptr < DEPTH_P;

    always_comb begin
        o_cmd.op         = OP_NONE;
        o_cmd.slot       = SLOT_M;
        o_cmd.has_letter = 1'b0;
        o_cmd.oor        = 1'b0;
        o_addr           = pos_ext[ADDR_W-1:0];
        n_ptr            = r_ptr;
        case (i_req.req_type)
            REQ_START: begin
                n_ptr     = pos_ext;
                o_cmd.oor = !(pos_ext < DEPTH_P);
            end
            REQ_MATCH: begin
                o_cmd.op = OP_MATCH;
                o_addr   = r_ptr[ADDR_W-1:0];
                case (i_req.base)
                    CH_A: begin
                        o_cmd.slot = SLOT_A;
                        o_cmd.has_letter = 1'b1;
                    end
                    CH_C: begin
                        o_cmd.slot = SLOT_C;
                        o_cmd.has_letter = 1'b1;
                    end
                    CH_G: begin
                        o_cmd.slot = SLOT_G;
                        o_cmd.has_letter = 1'b1;
                    end
                    CH_T: begin
                        o_cmd.slot = SLOT_T;
                        o_cmd.has_letter = 1'b1;
                    end
                    CH_N: begin
                        o_cmd.slot = SLOT_N;
                        o_cmd.has_letter = 1'b1;
                    end
                    default: ;
                endcase
                if (ptr_ok) begin
                    n_ptr = r_ptr + PTR_W'(1);
                end else begin
                    o_cmd.oor = 1'b1;
                end
            end
            REQ_DELETE: begin
                o_cmd.op = OP_DELETE;
                o_addr   = r_ptr[ADDR_W-1:0];
                if (ptr_ok) begin
                    n_ptr = r_ptr + PTR_W'(1);
                end else begin
                    o_cmd.oor = 1'b1;
                end
            end
            REQ_INSERT: begin
                o_cmd.op  = OP_INSERT;
                o_addr    = ptr_m1[ADDR_W-1:0];
                o_cmd.oor = (r_ptr == '0) || !(ptr_m1 < DEPTH_P);
            end
            REQ_READ: begin
                o_cmd.op  = OP_READ;
                o_cmd.oor = !(pos_ext < DEPTH_P);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (o_push) begin
            r_ptr <= n_ptr;
        end
    end

endmodule

// File: sv/apc_queue.sv
// Short command queue between the front end and the table back end.
// Depends on apc_pkg.
module apc_queue #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  apc_pkg::t_cmd     i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_full,
    output logic              o_valid,
    output apc_pkg::t_cmd     o_cmd,
    output logic [ADDR_W-1:0] o_addr,
    input  logic              i_pop
);
    import apc_pkg::*;

    localparam int QP_W = $clog2(Q_DEPTH);
    localparam int QC_W = QP_W + 1;

    t_cmd              r_cmd_q [Q_DEPTH];
    logic [ADDR_W-1:0] r_addr_q [Q_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_count;

    assign o_full  = r_count == QC_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_cmd_q[r_rd_ptr];
    assign o_addr  = r_addr_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_q[r_wr_ptr]  <= i_cmd;
            r_addr_q[r_wr_ptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue popped while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + QC_W'(1))
        else $error("queue count did not follow a push");

endmodule

// File: sv/apc_back.sv
// Back end: clears the count table after reset, then reads each command's entry and writes it back updated
// for an in-range match, delete or insert; holds the response in an output register. Depends on apc_pkg, apc_if.
module apc_back #(
    parameter int TABLE_DEPTH = 65536,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  apc_pkg::t_cmd     i_q_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_q_addr,
    output logic              o_pop,
    output logic              o_clear_busy,
    apc_rsp_if.source         o_rsp
);
    import apc_pkg::*;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = NUM_CNT * COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    t_bk_state         r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [COUNT_WIDTH-1:0] cur_cnt [NUM_CNT];
    logic [ENTRY_W-1:0]     new_entry;
    logic [NUM_CNT-1:0]     inc;
    logic [NUM_CNT-1:0]     sat;
    t_rsp                   result;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[i_q_addr];
        end
    end

    always_comb begin
        inc = '0;
        if (!r_cmd.oor) begin
            case (r_cmd.op)
                OP_MATCH: begin
                    inc[SLOT_M] = 1'b1;
                    if (r_cmd.has_letter) begin
                        inc[r_cmd.slot] = 1'b1;
                    end
                end
                OP_DELETE: inc[SLOT_D] = 1'b1;
                OP_INSERT: inc[SLOT_I] = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        result.status = ST_OK;
        for (int k = 0; k < NUM_CNT; k++) begin
            cur_cnt[k] = r_rd_data[k*COUNT_WIDTH +: COUNT_WIDTH];
            sat[k] = inc[k] && (cur_cnt[k] == COUNT_MAX);
            new_entry[k*COUNT_WIDTH +: COUNT_WIDTH] = (inc[k] && !sat[k]) ?
                cur_cnt[k] + COUNT_WIDTH'(1) : cur_cnt[k];
            result.count[k] = (r_cmd.op == OP_READ && !r_cmd.oor) ?
                CNT_OUT_W'(cur_cnt[k]) : '0;
        end
        if (|sat) begin
            result.status = ST_SAT;
        end else if (r_cmd.oor) begin
            result.status = ST_RANGE;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_rsp        = r_rsp;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        o_pop        = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = new_entry;
        o_clear_busy = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                o_clear_busy = 1'b1;
                wr_en        = 1'b1;
                wr_addr      = r_clr_addr;
                wr_data      = '0;
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            BK_IDLE: begin
                if (i_q_valid && (!r_rsp_valid || o_rsp.ready)) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = BK_DATA;
                end
            end
            BK_DATA: begin
                wr_en       = |inc;
                n_rsp       = result;
                n_rsp_valid = 1'b1;
                n_state     = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (o_pop) begin
            r_cmd  <= i_q_cmd;
            r_addr <= i_q_addr;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.count_a      = r_rsp.count[SLOT_A];
    assign o_rsp.count_c      = r_rsp.count[SLOT_C];
    assign o_rsp.count_g      = r_rsp.count[SLOT_G];
    assign o_rsp.count_t      = r_rsp.count[SLOT_T];
    assign o_rsp.count_n      = r_rsp.count[SLOT_N];
    assign o_rsp.count_match  = r_rsp.count[SLOT_M];
    assign o_rsp.count_insert = r_rsp.count[SLOT_I];
    assign o_rsp.count_delete = r_rsp.count[SLOT_D];

    a_pop_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == BK_DATA)
        else $error("popped command was not carried out");
    a_data_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DATA |=> r_rsp_valid)
        else $error("finished command gave no response");
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clear_busy |-> !o_pop && !o_rsp.valid)
        else $error("command handled during the clearing pass");

endmodule
